### rtl/core/ctc_pkg.sv
// shared constants and calendar helpers for the calendar time counter
package ctc_pkg;

  localparam int unsigned FieldWidth = 6;
  localparam int unsigned YearWidth  = 16;

  localparam logic [FieldWidth-1:0] SecondLast = 6'd59;
  localparam logic [FieldWidth-1:0] MinuteLast = 6'd59;
  localparam logic [FieldWidth-1:0] HourLast   = 6'd23;
  localparam logic [FieldWidth-1:0] MonthLast  = 6'd12;
  localparam logic [FieldWidth-1:0] FirstZero  = 6'd0;
  localparam logic [FieldWidth-1:0] FirstOne   = 6'd1;

  localparam logic [3:0] February  = 4'd2;
  localparam logic [3:0] April     = 4'd4;
  localparam logic [3:0] June      = 4'd6;
  localparam logic [3:0] September = 4'd9;
  localparam logic [3:0] November  = 4'd11;

  // inverse of 25 modulo 2^16, and the largest product of an exact multiple
  localparam logic [YearWidth-1:0] Inv25     = 16'd23593;
  localparam logic [YearWidth-1:0] Div25Max  = 16'd2621;

  localparam logic COMMAND_TICK = 1'b0;
  localparam logic COMMAND_LOAD = 1'b1;

  function automatic logic is_leap(input logic [YearWidth-1:0] year);
    logic [YearWidth-1:0] product;
    logic div25;
    product = year * Inv25;
    div25   = (product <= Div25Max);
    return (year[1:0] == 2'b00) && (!div25 || (year[3:0] == 4'b0000));
  endfunction

  function automatic logic [4:0] month_length(input logic [3:0] month, input logic leap);
    logic [4:0] days;
    case (month)
      February: days = leap ? 5'd29 : 5'd28;
      April, June, September, November: days = 5'd30;
      default: days = 5'd31;
    endcase
    return days;
  endfunction

endpackage

### rtl/core/ctc_in_if.sv
// request channel carrying tick and load items
interface ctc_in_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [5:0]  load_second;
  logic [5:0]  load_minute;
  logic [4:0]  load_hour;
  logic [4:0]  load_day;
  logic [3:0]  load_month;
  logic [15:0] load_year;

  modport source (
    output valid, command, load_second, load_minute, load_hour, load_day, load_month,
           load_year,
    input  ready
  );
  modport sink (
    input  valid, command, load_second, load_minute, load_hour, load_day, load_month,
           load_year,
    output ready
  );
endinterface

### rtl/core/ctc_out_if.sv
// result channel carrying the current calendar time
interface ctc_out_if;
  logic        valid;
  logic        ready;
  logic        time_valid;
  logic [5:0]  now_second;
  logic [5:0]  now_minute;
  logic [4:0]  now_hour;
  logic [4:0]  now_day;
  logic [3:0]  now_month;
  logic [15:0] now_year;

  modport source (
    output valid, time_valid, now_second, now_minute, now_hour, now_day, now_month,
           now_year,
    input  ready
  );
  modport sink (
    input  valid, time_valid, now_second, now_minute, now_hour, now_day, now_month,
           now_year,
    output ready
  );
endinterface

### rtl/core/calendar_time_counter.sv
// calendar time counter: a chain of field cells from second up to year
// an accepted item's result item is registered and appears in the next cycle
// throughput: one item per cycle; the carry chain across the cells settles in a cycle
// the result register is the time itself, so an item is taken whenever the result is free
// reset (synchronous): time 0:00:00 on day 1 of month 1, year 0, not valid
module calendar_time_counter (
  input  logic      clk,
  input  logic      rst,
  ctc_in_if.sink    request,
  ctc_out_if.source result
);

  logic       accept;
  logic       load;
  logic       tick;
  logic       valid_flag;
  logic       result_valid;
  logic       leap;
  logic [4:0] carry;
  logic       carry_unused;

  logic [ctc_pkg::FieldWidth-1:0] second_value;
  logic [ctc_pkg::FieldWidth-1:0] minute_value;
  logic [ctc_pkg::FieldWidth-1:0] hour_value;
  logic [ctc_pkg::FieldWidth-1:0] day_value;
  logic [ctc_pkg::FieldWidth-1:0] month_value;
  logic [ctc_pkg::FieldWidth-1:0] day_bound;
  logic [ctc_pkg::YearWidth-1:0]  year_value;

  assign request.ready = !result_valid || result.ready;
  assign accept = request.valid && request.ready;
  assign load   = accept && (request.command == ctc_pkg::COMMAND_LOAD);
  assign tick   = accept && (request.command == ctc_pkg::COMMAND_TICK) && valid_flag;

  assign day_bound = {1'b0, ctc_pkg::month_length(month_value[3:0], leap)};

  ctc_cell second_cell (
    .clk(clk), .rst(rst), .load(load), .tick(tick),
    .load_value(request.load_second),
    .bound(ctc_pkg::SecondLast), .first(ctc_pkg::FirstZero),
    .carry_in(1'b1), .carry_out(carry[0]), .value(second_value)
  );

  ctc_cell minute_cell (
    .clk(clk), .rst(rst), .load(load), .tick(tick),
    .load_value(request.load_minute),
    .bound(ctc_pkg::MinuteLast), .first(ctc_pkg::FirstZero),
    .carry_in(carry[0]), .carry_out(carry[1]), .value(minute_value)
  );

  ctc_cell hour_cell (
    .clk(clk), .rst(rst), .load(load), .tick(tick),
    .load_value({1'b0, request.load_hour}),
    .bound(ctc_pkg::HourLast), .first(ctc_pkg::FirstZero),
    .carry_in(carry[1]), .carry_out(carry[2]), .value(hour_value)
  );

  ctc_cell day_cell (
    .clk(clk), .rst(rst), .load(load), .tick(tick),
    .load_value({1'b0, request.load_day}),
    .bound(day_bound), .first(ctc_pkg::FirstOne),
    .carry_in(carry[2]), .carry_out(carry[3]), .value(day_value)
  );

  ctc_cell month_cell (
    .clk(clk), .rst(rst), .load(load), .tick(tick),
    .load_value({2'b00, request.load_month}),
    .bound(ctc_pkg::MonthLast), .first(ctc_pkg::FirstOne),
    .carry_in(carry[3]), .carry_out(carry[4]), .value(month_value)
  );

  ctc_year_cell year_cell (
    .clk(clk), .rst(rst), .load(load), .tick(tick),
    .load_value(request.load_year),
    .carry_in(carry[4]), .leap(leap), .value(year_value)
  );

  // upper bits of the narrow fields never get set, loads and first values keep them clear
  assign carry_unused = ^{hour_value[5], day_value[5], month_value[5:4]};

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_flag   <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (load) begin
        valid_flag <= 1'b1;
      end
      if (accept) begin
        result_valid <= 1'b1;
      end else if (result.ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  assign result.valid      = result_valid;
  assign result.time_valid = valid_flag;
  assign result.now_second = second_value;
  assign result.now_minute = minute_value;
  assign result.now_hour   = hour_value[4:0];
  assign result.now_day    = day_value[4:0] ^ {4'b0000, carry_unused & 1'b0};
  assign result.now_month  = month_value[3:0];
  assign result.now_year   = year_value;

endmodule

### rtl/core/ctc_cell.sv
// rollover counter cell for one calendar field below the year
module ctc_cell (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          load,
  input  logic                          tick,
  input  logic [ctc_pkg::FieldWidth-1:0] load_value,
  input  logic [ctc_pkg::FieldWidth-1:0] bound,
  input  logic [ctc_pkg::FieldWidth-1:0] first,
  input  logic                          carry_in,
  output logic                          carry_out,
  output logic [ctc_pkg::FieldWidth-1:0] value
);

  logic [ctc_pkg::FieldWidth:0]   sum;
  logic [ctc_pkg::FieldWidth-1:0] value_next;

  always_comb begin
    sum       = {1'b0, value} + {{ctc_pkg::FieldWidth{1'b0}}, carry_in};
    carry_out = (sum > {1'b0, bound});
    value_next = carry_out ? first : sum[ctc_pkg::FieldWidth-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      value <= first;
    end else if (load) begin
      value <= load_value;
    end else if (tick) begin
      value <= value_next;
    end
  end

endmodule

### rtl/core/ctc_year_cell.sv
// year cell at the end of the chain, wraps modulo 2^16 and reports leap years
module ctc_year_cell (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         load,
  input  logic                         tick,
  input  logic [ctc_pkg::YearWidth-1:0] load_value,
  input  logic                         carry_in,
  output logic                         leap,
  output logic [ctc_pkg::YearWidth-1:0] value
);

  always_comb begin
    leap = ctc_pkg::is_leap(value);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      value <= '0;
    end else if (load) begin
      value <= load_value;
    end else if (tick) begin
      value <= value + {{(ctc_pkg::YearWidth-1){1'b0}}, carry_in};
    end
  end

endmodule
